/* design/hal_pkg.sv */
// ----------------------------------------------------------------------------
// hal_pkg
// shared widths, operation and status codes, hash constant and defaults
// for the hashed address allowlist
// ----------------------------------------------------------------------------
`default_nettype none

package hal_pkg;

    // field widths
    localparam int ADDR_W   = 64;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = 11;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_START  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SKIP = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // 64-bit golden-ratio multiplier, split into halves
    localparam logic [63:0] GOLDEN64  = 64'h61C8_8646_80B5_83EB;
    localparam logic [31:0] GOLDEN_LO = GOLDEN64[31:0];
    localparam logic [31:0] GOLDEN_HI = GOLDEN64[63:32];

    // default sizing
    localparam int DEF_CAPACITY    = 1024;
    localparam int DEF_BUCKET_BITS = 11;
    localparam int DEF_WAYS        = 2;

endpackage

`default_nettype wire

/* design/hal_hash.sv */
// ----------------------------------------------------------------------------
// hal_hash
// multiplicative bucket hash: top bucket_bits of addr * golden64 mod 2^64,
// built from three registered 32x32 partial products and a three-operand 32-bit add
// ----------------------------------------------------------------------------
`default_nettype none

module hal_hash
    import hal_pkg::*;
#(
    parameter int BUCKET_BITS = DEF_BUCKET_BITS
)
(
    input  wire logic                   clk,
    input  wire logic [ADDR_W-1:0]      addr,
    output logic      [BUCKET_BITS-1:0] bucket
);

    logic [63:0] lo_lo_reg;
    logic [31:0] cross_a_reg;
    logic [31:0] cross_b_reg;
    logic [31:0] hi_sum;

    // partial products; cross terms only feed the upper word, low 32 bits kept
    always_ff @(posedge clk)
    begin
        lo_lo_reg   <= 64'(addr[31:0]) * 64'(GOLDEN_LO);
        cross_a_reg <= addr[63:32] * GOLDEN_LO;
        cross_b_reg <= addr[31:0] * GOLDEN_HI;
    end

    // upper word of the product, top bits select the bucket
    assign hi_sum = lo_lo_reg[63:32] + cross_a_reg + cross_b_reg;
    assign bucket = hi_sum[31 -: BUCKET_BITS];

endmodule

`default_nettype wire

/* design/hashed_address_allowlist.sv */
// ----------------------------------------------------------------------------
// hashed_address_allowlist
// set of allowed 64-bit addresses in a bucketed table held in one
// synchronous memory, one row per bucket with WAYS slots
// ----------------------------------------------------------------------------
//   channel  | signals                           | direction
//   ---------+-----------------------------------+----------
//   in       | in_valid, in_ready, func, addr    | sink
//   out      | out_valid, out_ready, allowed,    | source
//            | status, entry_count               |
//
// insert and lookup pass from accept to result through S_MUL (hash partial
// products), S_LOOK (bucket sum and row read), S_EVAL (compare and write
// back) and S_RESP (result load). start sweeps every bucket row, one row a
// cycle, and after reset the same sweep runs with in_ready low.
// one item is in flight at a time; in_ready returns while a result waits
// in the output register, and a stalled output holds the next result back.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_address_allowlist
    import hal_pkg::*;
#(
    parameter int CAPACITY    = DEF_CAPACITY,
    parameter int BUCKET_BITS = DEF_BUCKET_BITS,
    parameter int WAYS        = DEF_WAYS
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [FUNC_W-1:0]   func,
    input  wire logic [ADDR_W-1:0]   addr,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     allowed,
    output logic [STATUS_W-1:0]      status,
    output logic [ENTRY_W-1:0]       entry_count
);

    localparam int NUM_BUCKETS = 1 << BUCKET_BITS;
    localparam int COUNT_W     = $clog2(CAPACITY + 1);

    typedef struct packed {
        logic [WAYS-1:0]             valid;
        logic [WAYS-1:0][ADDR_W-1:0] addr;
    } row_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_LOOK,
        S_EVAL,
        S_RESP
    } state_t;

    state_t                 state_reg;
    logic [BUCKET_BITS-1:0] clr_idx_reg;
    logic                   from_start_reg;
    logic                   armed_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic                   res_allowed_reg;
    logic [STATUS_W-1:0]    res_status_reg;
    logic                   out_valid_reg;
    logic                   allowed_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic [ENTRY_W-1:0]     entry_count_reg;

    logic [FUNC_W-1:0]      func_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic [BUCKET_BITS-1:0] bucket_reg;
    logic [BUCKET_BITS-1:0] bucket;

    row_t                   mem [NUM_BUCKETS];
    row_t                   rd_row_reg;
    row_t                   wr_row;
    logic [BUCKET_BITS-1:0] wr_idx;
    logic                   wr_en;

    logic                   in_beat;
    logic                   out_free;
    logic [WAYS-1:0]        way_hit;
    logic                   hit;
    logic [WAYS-1:0]        free_oh;
    logic                   addr_zero;
    logic                   cap_full;
    logic                   add_now;
    logic                   allowed_next;
    logic [STATUS_W-1:0]    status_next;
    row_t                   upd_row;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_beat   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign allowed     = allowed_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;

    // bucket hash over the latched address
    hal_hash #(
        .BUCKET_BITS (BUCKET_BITS)
    ) u_hash (
        .clk    (clk),
        .addr   (addr_reg),
        .bucket (bucket)
    );

    // compare the ways of the bucket row
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            way_hit[w] = rd_row_reg.valid[w] && (rd_row_reg.addr[w] == addr_reg);
        end
    end

    assign hit       = |way_hit;
    assign free_oh   = ~rd_row_reg.valid & (rd_row_reg.valid + WAYS'(1));
    assign addr_zero = (addr_reg == '0);
    assign cap_full  = (count_reg >= COUNT_W'(CAPACITY));

    // decision for insert and lookup
    always_comb
    begin
        allowed_next = 1'b0;
        status_next  = ST_DONE;
        add_now      = 1'b0;
        unique case (func_reg)
            FUNC_INSERT:
            begin
                priority if (addr_zero || hit)
                begin
                    status_next = ST_SKIP;
                end
                else if (cap_full || (free_oh == '0))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    add_now = 1'b1;
                end
            end
            FUNC_LOOKUP:
            begin
                allowed_next = !armed_reg || (!addr_zero && hit);
            end
            default:
            begin
                allowed_next = 1'b0;
            end
        endcase
    end

    // row with the new address in the first free way
    always_comb
    begin
        upd_row.valid = rd_row_reg.valid | free_oh;
        for (int w = 0; w < WAYS; w++)
        begin
            upd_row.addr[w] = free_oh[w] ? addr_reg : rd_row_reg.addr[w];
        end
    end

    // write port: clearing sweep or insert write-back
    always_comb
    begin
        wr_en  = 1'b0;
        wr_idx = bucket_reg;
        wr_row = upd_row;
        if (state_reg == S_CLEAR)
        begin
            wr_en  = 1'b1;
            wr_idx = clr_idx_reg;
            wr_row = '0;
        end
        else if ((state_reg == S_EVAL) && add_now)
        begin
            wr_en = 1'b1;
        end
    end

    // bucket memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_row;
        end
        rd_row_reg <= mem[bucket];
    end

    // item payload and bucket index
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            func_reg <= func;
            addr_reg <= addr;
        end
        if (state_reg == S_LOOK)
        begin
            bucket_reg <= bucket;
        end
    end

    // control state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_idx_reg     <= '0;
            from_start_reg  <= 1'b0;
            armed_reg       <= 1'b0;
            count_reg       <= '0;
            res_allowed_reg <= 1'b0;
            res_status_reg  <= ST_DONE;
            out_valid_reg   <= 1'b0;
            allowed_reg     <= 1'b0;
            status_reg      <= ST_DONE;
            entry_count_reg <= '0;
        end
        else
        begin
            // output beat taken, unless a new result loads this cycle
            if (out_valid_reg && out_ready && (state_reg != S_RESP))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + BUCKET_BITS'(1);
                    if (clr_idx_reg == BUCKET_BITS'(NUM_BUCKETS - 1))
                    begin
                        state_reg <= from_start_reg ? S_RESP : S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_beat)
                    begin
                        res_allowed_reg <= 1'b0;
                        res_status_reg  <= ST_DONE;
                        if (func == FUNC_START)
                        begin
                            armed_reg      <= 1'b1;
                            count_reg      <= '0;
                            clr_idx_reg    <= '0;
                            from_start_reg <= 1'b1;
                            state_reg      <= S_CLEAR;
                        end
                        else if ((func == FUNC_INSERT) || (func == FUNC_LOOKUP))
                        begin
                            state_reg <= S_MUL;
                        end
                        else
                        begin
                            state_reg <= S_RESP;
                        end
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_LOOK;
                end
                S_LOOK:
                begin
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    res_allowed_reg <= allowed_next;
                    res_status_reg  <= status_next;
                    if (add_now)
                    begin
                        count_reg <= count_reg + COUNT_W'(1);
                    end
                    state_reg <= S_RESP;
                end
                S_RESP:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        allowed_reg     <= res_allowed_reg;
                        status_reg      <= res_status_reg;
                        entry_count_reg <= ENTRY_W'(count_reg);
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
